// File: rtl/core/idct_pkg.sv
// Shared types, widths and constants for the 8x8 integer inverse DCT.
// Used by idct_load, idct_xform and the top level idct_8x8_islow_pixels.
`default_nettype none
package idct_pkg;

   localparam int COEF_W  = 16;
   localparam int PIX_W   = 8;
   localparam int MUL_A_W = 19;
   localparam int MUL_K_W = 16;
   localparam int PROD_W  = MUL_A_W + MUL_K_W;
   localparam int ACC_W   = 36;
   localparam int ROW_SHIFT = 11;
   localparam int COL_SHIFT = 18;
   localparam int LEVEL_SHIFT = 128;

   // Multiplier steps of one 1-D transform, in issue order.
   localparam logic [3:0] STEP_EVEN_SUM = 4'd0;
   localparam logic [3:0] STEP_V6       = 4'd1;
   localparam logic [3:0] STEP_V2       = 4'd2;
   localparam logic [3:0] STEP_Z1       = 4'd3;
   localparam logic [3:0] STEP_Z2       = 4'd4;
   localparam logic [3:0] STEP_Z3       = 4'd5;
   localparam logic [3:0] STEP_Z4       = 4'd6;
   localparam logic [3:0] STEP_Z5       = 4'd7;
   localparam logic [3:0] STEP_V7       = 4'd8;
   localparam logic [3:0] STEP_V5       = 4'd9;
   localparam logic [3:0] STEP_V3       = 4'd10;
   localparam logic [3:0] STEP_V1       = 4'd11;
   localparam logic [3:0] STEP_COUNT    = 4'd12;

   typedef struct packed {
      logic ready;
      logic bank;
   } blk_status_type;

   typedef struct packed {
      logic release_bank;
   } xform_ctl_type;

   function automatic logic signed [MUL_K_W-1:0] mul_const(input logic [3:0] step);
      logic signed [MUL_K_W-1:0] k;
      k = '0;
      unique case (step)
         STEP_EVEN_SUM: k = 16'sd4433;
         STEP_V6:       k = 16'sd15137;
         STEP_V2:       k = 16'sd6270;
         STEP_Z1:       k = -16'sd7373;
         STEP_Z2:       k = -16'sd20995;
         STEP_Z3:       k = -16'sd16069;
         STEP_Z4:       k = -16'sd3196;
         STEP_Z5:       k = 16'sd9633;
         STEP_V7:       k = 16'sd2446;
         STEP_V5:       k = 16'sd16819;
         STEP_V3:       k = 16'sd25172;
         STEP_V1:       k = 16'sd12299;
         default:       k = '0;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/idct_load.sv
// Front end: accepts coefficients into a two-bank coefficient store and
// queues finished blocks for the transform engine. Depends on idct_pkg.
`default_nettype none
module idct_load (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [idct_pkg::COEF_W-1:0] req_coefficient,
   input  wire idct_pkg::xform_ctl_type       ctl,
   output idct_pkg::blk_status_type           status,
   input  wire logic [6:0]                    rd_addr,
   output logic signed [idct_pkg::COEF_W-1:0] rd_data
);
   import idct_pkg::*;

   logic [5:0] load_count_ff, load_count_in;
   logic       wbank_ff, wbank_in;
   logic       rbank_ff, rbank_in;
   logic [1:0] ready_count_ff, ready_count_in;
   logic       accept;
   logic       block_done;

   logic signed [COEF_W-1:0] coef_mem [128];
   logic signed [COEF_W-1:0] rd_data_ff;

   assign req_full   = (ready_count_ff == 2'd2);
   assign accept     = req_push && !req_full;
   assign block_done = accept && (load_count_ff == 6'd63);

   always_comb begin
      load_count_in  = accept ? load_count_ff + 6'd1 : load_count_ff;
      wbank_in       = block_done ? !wbank_ff : wbank_ff;
      rbank_in       = ctl.release_bank ? !rbank_ff : rbank_ff;
      ready_count_in = ready_count_ff;
      if (block_done && !ctl.release_bank) begin
         ready_count_in = ready_count_ff + 2'd1;
      end else if (!block_done && ctl.release_bank) begin
         ready_count_in = ready_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff  <= '0;
         wbank_ff       <= 1'b0;
         rbank_ff       <= 1'b0;
         ready_count_ff <= '0;
      end else begin
         load_count_ff  <= load_count_in;
         wbank_ff       <= wbank_in;
         rbank_ff       <= rbank_in;
         ready_count_ff <= ready_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         coef_mem[{wbank_ff, load_count_ff}] <= req_coefficient;
      end
      rd_data_ff <= coef_mem[rd_addr];
   end

   assign rd_data      = rd_data_ff;
   assign status.ready = (ready_count_ff != 2'd0);
   assign status.bank  = rbank_ff;

endmodule
`default_nettype wire

// File: rtl/core/idct_xform.sv
// Back end: row and column passes on one shared multiplier, the pixel
// store and a two-entry result queue. Depends on idct_pkg.
`default_nettype none
module idct_xform (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire idct_pkg::blk_status_type      status,
   output idct_pkg::xform_ctl_type            ctl,
   output logic [6:0]                         rd_addr,
   input  wire logic signed [idct_pkg::COEF_W-1:0] rd_data,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [idct_pkg::PIX_W-1:0]         rsp_pixel,
   output logic                               rsp_block_end
);
   import idct_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] line_ff, line_in;
   logic       col_ff, col_in;
   logic [6:0] dcnt_ff, dcnt_in;

   logic signed [COEF_W-1:0] v_ff [8];
   logic signed [PROD_W-1:0] p_ff [12];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  s_ff [4];
   logic signed [ACC_W-1:0]  o_ff [4];

   logic signed [COEF_W-1:0] work_mem [64];
   logic signed [COEF_W-1:0] work_rd_ff;
   logic [PIX_W-1:0]         pix_mem [64];
   logic [PIX_W-1:0]         pix_rd_ff;

   logic             pend_ff;
   logic             pend_last_ff;
   logic [PIX_W-1:0] fifo_pix_ff [2];
   logic             fifo_last_ff [2];
   logic [1:0]       fifo_count_ff, fifo_count_in;
   logic             fifo_head_ff;
   logic             fifo_tail_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_A_W-1:0] x1, x3, x5, x7, x2, x6;
   logic signed [COEF_W-1:0]  load_data;
   logic [2:0]                b;
   logic signed [ACC_W-1:0]   r_val;
   logic signed [ACC_W-1:0]   row_sum;
   logic signed [ACC_W-1:0]   col_sum;
   logic [COEF_W-1:0]         row_val;
   logic [COEF_W-1:0]         col_val;
   logic [COEF_W-1:0]         level;
   logic [PIX_W-1:0]          pix_val;
   logic                      out_wr;
   logic                      issue;
   logic                      pop;
   logic [2:0]                occ;

   logic signed [ACC_W-1:0] pe [12];
   logic signed [ACC_W-1:0] e0, e1, e2, e3, m3, m4;

   assign b = cnt_ff[2:0];

   // Read ports: coefficients for the row pass, column-wise work values after it.
   assign rd_addr   = {status.bank, line_ff, b};
   assign load_data = col_ff ? work_rd_ff : rd_data;

   always_comb begin
      x1 = MUL_A_W'(v_ff[1]);
      x2 = MUL_A_W'(v_ff[2]);
      x3 = MUL_A_W'(v_ff[3]);
      x5 = MUL_A_W'(v_ff[5]);
      x6 = MUL_A_W'(v_ff[6]);
      x7 = MUL_A_W'(v_ff[7]);
      mul_a = '0;
      unique case (cnt_ff)
         STEP_EVEN_SUM: mul_a = x2 + x6;
         STEP_V6:       mul_a = x6;
         STEP_V2:       mul_a = x2;
         STEP_Z1:       mul_a = x7 + x1;
         STEP_Z2:       mul_a = x5 + x3;
         STEP_Z3:       mul_a = x7 + x3;
         STEP_Z4:       mul_a = x5 + x1;
         STEP_Z5:       mul_a = x7 + x5 + x3 + x1;
         STEP_V7:       mul_a = x7;
         STEP_V5:       mul_a = x5;
         STEP_V3:       mul_a = x3;
         STEP_V1:       mul_a = x1;
         default:       mul_a = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         pe[i] = ACC_W'(p_ff[i]);
      end
      e2 = pe[STEP_EVEN_SUM] - pe[STEP_V6];
      e3 = pe[STEP_EVEN_SUM] + pe[STEP_V2];
      e0 = (ACC_W'(v_ff[0]) + ACC_W'(v_ff[4])) <<< 13;
      e1 = (ACC_W'(v_ff[0]) - ACC_W'(v_ff[4])) <<< 13;
      m3 = pe[STEP_Z3] + pe[STEP_Z5];
      m4 = pe[STEP_Z4] + pe[STEP_Z5];
   end

   // Output butterfly: outputs 0..3 add the odd term, 4..7 subtract it.
   always_comb begin
      if (!b[2]) begin
         r_val = s_ff[b[1:0]] + o_ff[~b[1:0]];
      end else begin
         r_val = s_ff[~b[1:0]] - o_ff[b[1:0]];
      end
      row_sum = r_val + (ACC_W'(1) <<< (ROW_SHIFT - 1));
      col_sum = r_val + (ACC_W'(1) <<< (COL_SHIFT - 1));
      row_val = row_sum[ROW_SHIFT+COEF_W-1:ROW_SHIFT];
      col_val = col_sum[COL_SHIFT+COEF_W-1:COL_SHIFT];
      level   = col_val + COEF_W'(LEVEL_SHIFT);
      if (level[COEF_W-1]) begin
         pix_val = '0;
      end else if (|level[COEF_W-2:PIX_W]) begin
         pix_val = '1;
      end else begin
         pix_val = level[PIX_W-1:0];
      end
   end

   assign out_wr = (state_ff == ST_OUT);
   assign pop    = rsp_pop && !rsp_empty;
   assign occ    = 3'(fifo_count_ff) + 3'(pend_ff) - 3'(pop);
   assign issue  = (state_ff == ST_DRAIN) && (dcnt_ff != 7'd64) && (occ < 3'd2);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      dcnt_in  = dcnt_ff;
      ctl.release_bank = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.ready) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
               line_in  = '0;
               col_in   = 1'b0;
            end
         end
         ST_LOAD: begin
            if (cnt_ff == 4'd8) begin
               state_in = ST_MUL;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_MUL: begin
            if (cnt_ff == STEP_COUNT) begin
               state_in = ST_FIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_FIN: begin
            state_in = ST_OUT;
            cnt_in   = '0;
         end
         ST_OUT: begin
            if (cnt_ff == 4'd7) begin
               cnt_in = '0;
               if (line_ff == 3'd7) begin
                  line_in = '0;
                  if (!col_ff) begin
                     ctl.release_bank = 1'b1;
                     col_in   = 1'b1;
                     state_in = ST_LOAD;
                  end else begin
                     dcnt_in  = '0;
                     state_in = ST_DRAIN;
                  end
               end else begin
                  line_in  = line_ff + 3'd1;
                  state_in = ST_LOAD;
               end
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               dcnt_in = dcnt_ff + 7'd1;
            end else if (dcnt_ff == 7'd64) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fifo_count_in = fifo_count_ff;
      if (pend_ff && !pop) begin
         fifo_count_in = fifo_count_ff + 2'd1;
      end else if (!pend_ff && pop) begin
         fifo_count_in = fifo_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         line_ff       <= '0;
         col_ff        <= 1'b0;
         dcnt_ff       <= '0;
         pend_ff       <= 1'b0;
         fifo_count_ff <= '0;
         fifo_head_ff  <= 1'b0;
         fifo_tail_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         dcnt_ff       <= dcnt_in;
         pend_ff       <= issue;
         fifo_count_ff <= fifo_count_in;
         if (pop) begin
            fifo_head_ff <= !fifo_head_ff;
         end
         if (pend_ff) begin
            fifo_tail_ff <= !fifo_tail_ff;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && cnt_ff != 4'd0) begin
         v_ff[3'(cnt_ff - 4'd1)] <= load_data;
      end
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_const(cnt_ff));
      if (state_ff == ST_MUL && cnt_ff != 4'd0) begin
         p_ff[cnt_ff - 4'd1] <= prod_ff;
      end
      if (state_ff == ST_FIN) begin
         s_ff[0] <= e0 + e3;
         s_ff[1] <= e1 + e2;
         s_ff[2] <= e1 - e2;
         s_ff[3] <= e0 - e3;
         o_ff[0] <= pe[STEP_V7] + pe[STEP_Z1] + m3;
         o_ff[1] <= pe[STEP_V5] + pe[STEP_Z2] + m4;
         o_ff[2] <= pe[STEP_V3] + pe[STEP_Z2] + m3;
         o_ff[3] <= pe[STEP_V1] + pe[STEP_Z1] + m4;
      end
      pend_last_ff <= (dcnt_ff == 7'd63);
      if (pend_ff) begin
         fifo_pix_ff[fifo_tail_ff]  <= pix_rd_ff;
         fifo_last_ff[fifo_tail_ff] <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_wr && !col_ff) begin
         work_mem[{line_ff, b}] <= row_val;
      end
      work_rd_ff <= work_mem[{b, line_ff}];
   end

   always_ff @(posedge clock) begin
      if (out_wr && col_ff) begin
         pix_mem[{b, line_ff}] <= pix_val;
      end
      pix_rd_ff <= pix_mem[dcnt_ff[5:0]];
   end

   assign rsp_empty     = (fifo_count_ff == 2'd0);
   assign rsp_pixel     = fifo_pix_ff[fifo_head_ff];
   assign rsp_block_end = fifo_last_ff[fifo_head_ff];

endmodule
`default_nettype wire

// File: rtl/core/idct_8x8_islow_pixels.sv
// Top level of the 8x8 integer inverse DCT producing 8-bit pixels.
// Depends on idct_pkg, idct_load and idct_xform.
//
// Usage: coefficients of one 8x8 block enter in row-major order on the
// req_ channel (push/full); a transaction is taken when push is high and
// full is low. After the 64th coefficient the block runs the row pass and
// then the column pass, each as eight 1-D transforms (8-entry load,
// 12 products on one shared multiplier, a combine step, 8 write-backs),
// then streams the 64 pixels in row-major order on the rsp_ channel
// (empty/pop), block_end on the last. Two coefficient banks let the next
// block load during the transform; full rises only when both banks hold
// blocks whose row pass has not finished. Reset clears all control state
// and the result queue. When the receiver stalls, the two-entry result
// queue fills and pixel read-out pauses; nothing is lost.
`default_nettype none
module idct_8x8_islow_pixels (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic signed [idct_pkg::COEF_W-1:0] req_coefficient,
   output logic                               empty,
   input  wire logic                          pop,
   output logic [idct_pkg::PIX_W-1:0]         rsp_pixel,
   output logic                               rsp_block_end
);
   import idct_pkg::*;

   blk_status_type           status;
   xform_ctl_type            ctl;
   logic [6:0]               rd_addr;
   logic signed [COEF_W-1:0] rd_data;

   idct_load u_load (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_full        (full),
      .req_coefficient (req_coefficient),
      .ctl             (ctl),
      .status          (status),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   idct_xform u_xform (
      .clock         (clock),
      .reset         (reset),
      .status        (status),
      .ctl           (ctl),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_pixel     (rsp_pixel),
      .rsp_block_end (rsp_block_end)
   );

endmodule
`default_nettype wire
